// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the sequencer back stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define FEPS_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sequencer invariant violated");

// Check that a condition implies another in the same cycle.
`define FEPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer implication violated");

`endif

// ----- hdl/feps_pkg.sv -----
`default_nettype none
package feps_pkg;

  localparam int LOGICAL_PAGES      = 4;
  localparam int LOGICAL_PAGE_BYTES = 2048;
  localparam int ERASE_UNIT_BYTES   = 1024;
  localparam int ERASE_UNITS        = 2;
  localparam int PROGRAM_BURST      = 4;
  localparam int MAX_RESULTS        = 4;
  localparam int BURST = (PROGRAM_BURST < MAX_RESULTS) ? PROGRAM_BURST : MAX_RESULTS;

  localparam int BUF_DEPTH = 512;
  localparam int BUF_AW    = 9;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [31:0] FLASH_END_RST     = 32'd134348799;
  localparam logic [15:0] ERASE_TIMEOUT_RST = 16'd1000;

  localparam logic [2:0] REQ_TICK       = 3'd0;
  localparam logic [2:0] REQ_LOAD       = 3'd1;
  localparam logic [2:0] REQ_ERASE_PROG = 3'd2;
  localparam logic [2:0] REQ_ERASE      = 3'd3;
  localparam logic [2:0] REQ_PROG       = 3'd4;
  localparam logic [2:0] REQ_DONE       = 3'd5;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_UNLOCK  = 2'd1;
  localparam logic [1:0] CMD_ERASE   = 2'd2;
  localparam logic [1:0] CMD_PROGRAM = 2'd3;

  localparam logic CFG_FLASH_END_ADDR = 1'b0;
  localparam logic CFG_ERASE_TIMEOUT  = 1'b1;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_LOAD,
    KIND_ERASE_PROG,
    KIND_ERASE,
    KIND_PROG,
    KIND_DONE
  } feps_kind_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    feps_kind_t  kind;
    logic        chk_ok;
    logic [31:0] span;
    logic [8:0]  offs_w;
    logic [8:0]  len_w;
    logic [8:0]  widx;
    logic [31:0] data;
    logic        sus;
    logic        res;
  } feps_item_t;

endpackage
`default_nettype wire

// ----- hdl/feps_ifs.sv -----
`default_nettype none
interface feps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  page_id;
  logic [10:0] byte_offset;
  logic [11:0] byte_len;
  logic [8:0]  word_index;
  logic [31:0] data_word;
  logic        suspend_granted;
  logic        resume_granted;

  modport source (output valid, req_type, page_id, byte_offset, byte_len, word_index,
                  data_word, suspend_granted, resume_granted, input ready);
  modport sink (input valid, req_type, page_id, byte_offset, byte_len, word_index,
                data_word, suspend_granted, resume_granted, output ready);
endinterface

interface feps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] flash_addr;
  logic [31:0] prog_word;
  logic        accepted;
  logic        error;
  logic        busy_res;
  logic        last;

  modport source (output valid, cmd, flash_addr, prog_word, accepted, error, busy_res,
                  last, input ready);
  modport sink (input valid, cmd, flash_addr, prog_word, accepted, error, busy_res,
                last, output ready);
endinterface

interface feps_cfg_if;
  logic        valid;
  logic        ready;
  logic        addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/feps_ram.sv -----
`default_nettype none
module feps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/feps_front.sv -----
`default_nettype none
module feps_front import feps_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  feps_in_if.sink     in_if,
  output logic        q_valid,
  output feps_item_t  q_item,
  input  wire logic   q_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  feps_item_t     slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  feps_item_t     item_d;
  logic           push, pop;
  logic           page_ok, len_ok, align_ok;

  // Classify the word; checks that need no sequencer state are done here.
  always_comb begin
    page_ok  = 7'(in_if.page_id) < 7'(LOGICAL_PAGES);
    len_ok   = in_if.byte_len < 12'(LOGICAL_PAGE_BYTES);
    align_ok = in_if.byte_offset[1:0] == 2'b00;

    item_d        = '0;
    item_d.span   = (32'(LOGICAL_PAGES) - 32'(in_if.page_id)) * 32'(LOGICAL_PAGE_BYTES);
    item_d.offs_w = in_if.byte_offset[10:2];
    item_d.len_w  = in_if.byte_len[10:2];
    item_d.widx   = in_if.word_index;
    item_d.data   = in_if.data_word;
    item_d.sus    = in_if.suspend_granted;
    item_d.res    = in_if.resume_granted;

    case (in_if.req_type)
      REQ_TICK: begin
        item_d.kind = KIND_TICK;
      end
      REQ_LOAD: begin
        item_d.kind = KIND_LOAD;
      end
      REQ_ERASE_PROG: begin
        item_d.kind   = KIND_ERASE_PROG;
        item_d.chk_ok = page_ok && len_ok;
      end
      REQ_ERASE: begin
        item_d.kind   = KIND_ERASE;
        item_d.chk_ok = page_ok;
      end
      REQ_PROG: begin
        item_d.kind   = KIND_PROG;
        item_d.chk_ok = page_ok && len_ok && align_ok;
      end
      REQ_DONE: begin
        item_d.kind = KIND_DONE;
      end
      default: begin
        item_d.kind = KIND_NONE;
      end
    endcase
  end

  assign in_if.ready = count_r != CW'(DEPTH);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = count_r != '0;
  assign q_item      = slot_r[rd_ptr_r];
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/feps_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module feps_back import feps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire feps_item_t  q_item,
  output logic             q_ready,
  feps_out_if.source       out_if,
  feps_cfg_if.sink         cfg_if
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_UNLOCK,
    PH_SUSPEND_WAIT,
    PH_ERASE,
    PH_ERASE_WAIT,
    PH_RESUME_WAIT,
    PH_PROGRAM,
    PH_PROGRAM_WAIT
  } phase_t;

  typedef enum logic {
    SQ_EXEC,
    SQ_BURST
  } seq_t;

  seq_t        sq_r, sq_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] base_r, base_nxt;
  logic [2:0]  eud_r, eud_nxt;
  logic [10:0] nw_r, nw_nxt;
  logic [10:0] ew_r, ew_nxt;
  logic [8:0]  src_r, src_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        eonly_r, eonly_nxt;
  logic [15:0] to_r, to_nxt;
  logic [2:0]  nburst_r, nburst_nxt;
  logic [31:0] flash_end_r, flash_end_nxt;
  logic [15:0] erase_to_r, erase_to_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  ocmd_r, ocmd_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic        oacc_r, oacc_nxt;
  logic        oerr_r, oerr_nxt;
  logic        obusy_r, obusy_nxt;
  logic        olast_r, olast_nxt;

  logic              slot_free;
  logic              emit;
  logic              acc, err;
  logic              burst_done;
  logic [1:0]        cmd;
  logic [31:0]       caddr;
  logic [10:0]       nw_sel;
  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  feps_ram #(
    .WIDTH (32),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_item.widx),
    .wdata (q_item.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free    = !ov_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  // Source index of the word being fetched: current word, or the one after it mid-burst.
  assign nw_sel    = (sq_r == SQ_BURST) ? nw_r + 11'd1 : nw_r;
  assign ram_raddr = nw_sel[8:0] - src_r;

  always_comb begin
    sq_nxt        = sq_r;
    phase_nxt     = phase_r;
    base_nxt      = base_r;
    eud_nxt       = eud_r;
    nw_nxt        = nw_r;
    ew_nxt        = ew_r;
    src_nxt       = src_r;
    pend_nxt      = pend_r;
    eonly_nxt     = eonly_r;
    to_nxt        = to_r;
    nburst_nxt    = nburst_r;
    flash_end_nxt = flash_end_r;
    erase_to_nxt  = erase_to_r;
    ov_nxt        = ov_r && !out_if.ready;
    ocmd_nxt      = ocmd_r;
    oaddr_nxt     = oaddr_r;
    oword_nxt     = oword_r;
    oacc_nxt      = oacc_r;
    oerr_nxt      = oerr_r;
    obusy_nxt     = obusy_r;
    olast_nxt     = olast_r;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    emit          = 1'b0;
    acc           = 1'b0;
    err           = 1'b0;
    burst_done    = 1'b0;
    cmd           = CMD_NONE;
    caddr         = '0;

    if (cfg_if.valid) begin
      case (cfg_if.addr)
        CFG_FLASH_END_ADDR: flash_end_nxt = cfg_if.data;
        CFG_ERASE_TIMEOUT:  erase_to_nxt  = cfg_if.data[15:0];
        default:            flash_end_nxt = flash_end_r;
      endcase
    end

    case (sq_r)
      SQ_EXEC: begin
        if (q_valid && slot_free) begin
          q_ready = 1'b1;
          emit    = 1'b1;
          case (q_item.kind)
            KIND_TICK: begin
              case (phase_r)
                PH_UNLOCK: begin
                  cmd       = CMD_UNLOCK;
                  phase_nxt = PH_SUSPEND_WAIT;
                end
                PH_SUSPEND_WAIT: begin
                  if (eud_r >= 3'(ERASE_UNITS)) begin
                    phase_nxt = eonly_r ? PH_IDLE : PH_PROGRAM;
                  end else if (q_item.sus) begin
                    phase_nxt = PH_ERASE;
                  end
                end
                PH_ERASE: begin
                  cmd       = CMD_ERASE;
                  caddr     = base_r + 32'(eud_r) * 32'(ERASE_UNIT_BYTES);
                  eud_nxt   = eud_r + 3'd1;
                  to_nxt    = erase_to_r;
                  phase_nxt = PH_ERASE_WAIT;
                end
                PH_ERASE_WAIT: begin
                  if (to_r == '0) begin
                    phase_nxt = PH_RESUME_WAIT;
                  end else begin
                    to_nxt = to_r - 16'd1;
                  end
                end
                PH_RESUME_WAIT: begin
                  if (q_item.res) begin
                    phase_nxt = PH_SUSPEND_WAIT;
                  end
                end
                PH_PROGRAM: begin
                  pend_nxt  = '0;
                  phase_nxt = PH_PROGRAM_WAIT;
                  if (nw_r < ew_r) begin
                    // Hold the item and fetch the first word of the burst.
                    emit       = 1'b0;
                    q_ready    = 1'b0;
                    ram_re     = 1'b1;
                    nburst_nxt = '0;
                    sq_nxt     = SQ_BURST;
                  end
                end
                PH_PROGRAM_WAIT: begin
                  if (pend_r == '0) begin
                    phase_nxt = (nw_r >= ew_r) ? PH_IDLE : PH_PROGRAM;
                  end
                end
                default: begin
                  phase_nxt = phase_r;
                end
              endcase
            end
            KIND_LOAD: begin
              ram_we = 1'b1;
            end
            KIND_ERASE_PROG: begin
              if (q_item.chk_ok && phase_r == PH_IDLE) begin
                base_nxt  = flash_end_r - q_item.span + 32'd1;
                phase_nxt = PH_UNLOCK;
                ew_nxt    = 11'(q_item.len_w);
                nw_nxt    = '0;
                src_nxt   = '0;
                eud_nxt   = '0;
                eonly_nxt = 1'b0;
                acc       = 1'b1;
              end
            end
            KIND_ERASE: begin
              if (q_item.chk_ok && phase_r == PH_IDLE) begin
                base_nxt  = flash_end_r - q_item.span + 32'd1;
                phase_nxt = PH_UNLOCK;
                eud_nxt   = '0;
                eonly_nxt = 1'b1;
                acc       = 1'b1;
              end
            end
            KIND_PROG: begin
              if (q_item.chk_ok && phase_r == PH_IDLE) begin
                base_nxt  = flash_end_r - q_item.span + 32'd1;
                nw_nxt    = 11'(q_item.offs_w);
                src_nxt   = q_item.offs_w;
                ew_nxt    = 11'(q_item.offs_w) + 11'(q_item.len_w);
                phase_nxt = PH_PROGRAM;
                eonly_nxt = 1'b0;
                acc       = 1'b1;
              end
            end
            KIND_DONE: begin
              if (phase_r == PH_ERASE_WAIT) begin
                phase_nxt = PH_RESUME_WAIT;
              end else if (phase_r == PH_PROGRAM_WAIT && pend_r != '0) begin
                pend_nxt = pend_r - 3'd1;
              end else begin
                err = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (emit) begin
            ov_nxt    = 1'b1;
            ocmd_nxt  = cmd;
            oaddr_nxt = caddr;
            oword_nxt = '0;
            oacc_nxt  = acc;
            oerr_nxt  = err;
            obusy_nxt = phase_nxt != PH_IDLE;
            olast_nxt = 1'b1;
          end
        end
      end
      SQ_BURST: begin
        if (slot_free) begin
          burst_done = (nburst_r + 3'd1 == 3'(BURST)) || (nw_r + 11'd1 >= ew_r);
          ov_nxt     = 1'b1;
          ocmd_nxt   = CMD_PROGRAM;
          oaddr_nxt  = base_r + {19'd0, nw_r, 2'b00};
          oword_nxt  = ram_rdata;
          oacc_nxt   = 1'b0;
          oerr_nxt   = 1'b0;
          obusy_nxt  = 1'b1;
          olast_nxt  = burst_done;
          pend_nxt   = pend_r + 3'd1;
          nw_nxt     = nw_r + 11'd1;
          nburst_nxt = nburst_r + 3'd1;
          if (burst_done) begin
            q_ready = 1'b1;
            sq_nxt  = SQ_EXEC;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      default: begin
        sq_nxt = SQ_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_EXEC;
      phase_r     <= PH_IDLE;
      base_r      <= '0;
      eud_r       <= '0;
      nw_r        <= '0;
      ew_r        <= '0;
      src_r       <= '0;
      pend_r      <= '0;
      eonly_r     <= 1'b0;
      to_r        <= '0;
      nburst_r    <= '0;
      flash_end_r <= FLASH_END_RST;
      erase_to_r  <= ERASE_TIMEOUT_RST;
      ov_r        <= 1'b0;
    end else begin
      sq_r        <= sq_nxt;
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      eud_r       <= eud_nxt;
      nw_r        <= nw_nxt;
      ew_r        <= ew_nxt;
      src_r       <= src_nxt;
      pend_r      <= pend_nxt;
      eonly_r     <= eonly_nxt;
      to_r        <= to_nxt;
      nburst_r    <= nburst_nxt;
      flash_end_r <= flash_end_nxt;
      erase_to_r  <= erase_to_nxt;
      ov_r        <= ov_nxt;
    end
    ocmd_r  <= ocmd_nxt;
    oaddr_r <= oaddr_nxt;
    oword_r <= oword_nxt;
    oacc_r  <= oacc_nxt;
    oerr_r  <= oerr_nxt;
    obusy_r <= obusy_nxt;
    olast_r <= olast_nxt;
  end

  assign out_if.valid      = ov_r;
  assign out_if.cmd        = ocmd_r;
  assign out_if.flash_addr = oaddr_r;
  assign out_if.prog_word  = oword_r;
  assign out_if.accepted   = oacc_r;
  assign out_if.error      = oerr_r;
  assign out_if.busy_res   = obusy_r;
  assign out_if.last       = olast_r;

  `FEPS_ASSERT_ALWAYS(a_pend_max, clk, rst_n, pend_r <= 3'(BURST))
  `FEPS_ASSERT_IMPLIES(a_burst_in_range, clk, rst_n, sq_r == SQ_BURST, nw_r < ew_r)
  `FEPS_ASSERT_IMPLIES(a_idle_no_pend, clk, rst_n, phase_r == PH_IDLE, pend_r == 3'd0)
  `FEPS_ASSERT_IMPLIES(a_prog_in_wait, clk, rst_n, ov_r && ocmd_r == CMD_PROGRAM, obusy_r && phase_r == PH_PROGRAM_WAIT)

endmodule
`default_nettype wire

// ----- hdl/flash_erase_program_sequencer.sv -----
// Flash erase/program sequencer. Words enter on in_if (valid/ready): ticks, page buffer
// loads, start requests (erase+program, erase only, program only at a word offset) and
// done events. A front stage classifies each word and checks page, length and alignment,
// then queues it (QUEUE_DEPTH entries); a back stage runs the phase machine (unlock,
// suspend handshake, per-unit erase with timeout, resume, program bursts) and writes one
// result word per cycle into an output register that holds while out_if.ready is low.
// Each input word yields one result word, except a program tick, which yields one per
// program command (up to four), marked by last on the final one. A word leaves the back
// stage when the output register is free; a program tick makes one buffer read per
// command, the first before any result is written, through the single read port of the
// page buffer RAM, whose read data is registered. Start requests are taken only while
// idle; a rejected one reports accepted low. A done event that nothing waits for reports
// error high and leaves the state alone. Write cfg_if (index 0: flash end address,
// index 1: erase timeout in ticks) only while the block is idle; cfg_if.ready is always
// high. Load a page buffer entry before any program command reads it.
`default_nettype none
module flash_erase_program_sequencer import feps_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  feps_in_if.sink     in_if,
  feps_out_if.source  out_if,
  feps_cfg_if.sink    cfg_if
);

  // Classified words travel from front to back through this queue port.
  logic       q_valid;
  logic       q_ready;
  feps_item_t q_item;

  // Front: classify and queue; stalls only when the queue is full.
  feps_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  // Back: advance the phase machine, drive the page buffer and the result register.
  feps_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_if  (out_if),
    .cfg_if  (cfg_if)
  );

endmodule
`default_nettype wire
